FILE: hw/rtl/assert_macros.svh
// Assertion helpers, clocked on the rising edge and disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define CHK_IMPLY(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/mmst_pkg.sv
`default_nettype none

package mmst_pkg;

    localparam int SAMPLE_WIDTH = 32;

    // Field widths
    localparam int GAIN_W = 17;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 2;

    // Derived datapath widths
    localparam int D_W     = SAMPLE_WIDTH + 1;         // x - min, signed
    localparam int R_W     = SAMPLE_WIDTH;             // max - min, unsigned
    localparam int P_W     = GAIN_W + 1 + D_W;         // gain * delta, signed
    localparam int M_W     = P_W + BYTE_W + 1;         // numerator, signed
    localparam int HALF_SH = 15;                       // range * 32768 rounding term
    localparam int DEN_SH  = 16;                       // range * 65536 denominator
    localparam int RQ_W    = R_W + DEN_SH + BYTE_W;    // remainder / shifted divisor
    localparam int STEP_W  = $clog2(BYTE_W);

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
    localparam logic [BYTE_W-1:0] BYTE_MAX = '1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BYTE_W - 1);

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_RED_GAIN   = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_GREEN_GAIN = IDX_W'(1);
    localparam logic [IDX_W-1:0] CFG_BLUE_GAIN  = IDX_W'(2);

    localparam int NUM_CH = 3;

    // Queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [R_W-1:0] range;
        logic [D_W-1:0] delta;   // two's complement
    } chan_op_t;

    typedef struct packed {
        chan_op_t [NUM_CH-1:0] ch;   // 0 red, 1 green, 2 blue
        logic                  last;
    } q_entry_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic check;
        logic step;
    } lane_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mmst_front.sv
`default_nettype none

module mmst_front (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    input  wire logic                                    op,
    input  wire logic                                    first,
    input  wire logic [mmst_pkg::SAMPLE_WIDTH-1:0]       red_sample,
    input  wire logic [mmst_pkg::SAMPLE_WIDTH-1:0]       green_sample,
    input  wire logic [mmst_pkg::SAMPLE_WIDTH-1:0]       blue_sample,
    input  wire logic                                    last,
    input  wire logic                                    q_full,
    output logic                                         push,
    output mmst_pkg::q_entry_t                           push_data
);

    logic signed [mmst_pkg::SAMPLE_WIDTH-1:0] min_reg  [mmst_pkg::NUM_CH];
    logic signed [mmst_pkg::SAMPLE_WIDTH-1:0] max_reg  [mmst_pkg::NUM_CH];
    logic signed [mmst_pkg::SAMPLE_WIDTH-1:0] min_next [mmst_pkg::NUM_CH];
    logic signed [mmst_pkg::SAMPLE_WIDTH-1:0] max_next [mmst_pkg::NUM_CH];
    logic signed [mmst_pkg::SAMPLE_WIDTH-1:0] x        [mmst_pkg::NUM_CH];
    logic                                     accept;
    logic signed [mmst_pkg::D_W-1:0]          span;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && op;

    assign x[0] = $signed(red_sample);
    assign x[1] = $signed(green_sample);
    assign x[2] = $signed(blue_sample);

    always_comb
    begin
        span = '0;
        for (int c = 0; c < mmst_pkg::NUM_CH; c++)
        begin
            min_next[c] = min_reg[c];
            max_next[c] = max_reg[c];
            if (accept && !op)
            begin
                if (first)
                begin
                    min_next[c] = x[c];
                    max_next[c] = x[c];
                end
                else
                begin
                    if (x[c] < min_reg[c])
                        min_next[c] = x[c];
                    if (x[c] > max_reg[c])
                        max_next[c] = x[c];
                end
            end
            // Snapshot the current range so later measure transfers cannot disturb it
            span = mmst_pkg::D_W'(max_reg[c]) - mmst_pkg::D_W'(min_reg[c]);
            push_data.ch[c].range = span[mmst_pkg::R_W-1:0];
            push_data.ch[c].delta = mmst_pkg::D_W'(x[c]) - mmst_pkg::D_W'(min_reg[c]);
        end
        push_data.last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < mmst_pkg::NUM_CH; c++)
            begin
                min_reg[c] <= '0;
                max_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < mmst_pkg::NUM_CH; c++)
            begin
                min_reg[c] <= min_next[c];
                max_reg[c] <= max_next[c];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mmst_fifo.sv
`default_nettype none

module mmst_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  mmst_pkg::q_entry_t       push_data,
    input  wire logic                pop,
    output mmst_pkg::q_entry_t       pop_data,
    output mmst_pkg::q_stat_t        stat
);

    mmst_pkg::q_entry_t                 mem_reg [mmst_pkg::Q_DEPTH];
    logic [mmst_pkg::Q_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mmst_pkg::Q_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mmst_pkg::Q_CNT_W-1:0]       count_reg, count_next;

    assign pop_data   = mem_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = count_reg == mmst_pkg::Q_CNT_W'(mmst_pkg::Q_DEPTH);
    assign stat.empty = count_reg == '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == mmst_pkg::Q_PTR_W'(mmst_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == mmst_pkg::Q_PTR_W'(mmst_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mmst_lane.sv
`default_nettype none

module mmst_lane (
    input  wire logic                          clk,
    input  mmst_pkg::lane_ctrl_t               ctrl,
    input  mmst_pkg::chan_op_t                 opnd,
    input  wire logic [mmst_pkg::GAIN_W-1:0]   gain,
    output logic [mmst_pkg::BYTE_W-1:0]        result
);

    logic        [mmst_pkg::D_W-1:0]     delta_reg, delta_next;
    logic        [mmst_pkg::R_W-1:0]     range_reg, range_next;
    logic signed [mmst_pkg::P_W-1:0]     prod_reg, prod_next;
    logic signed [mmst_pkg::M_W-1:0]     num_reg, num_next;
    logic        [mmst_pkg::RQ_W-1:0]    rem_reg, rem_next;
    logic        [mmst_pkg::RQ_W-1:0]    div_reg, div_next;
    logic        [mmst_pkg::BYTE_W-1:0]  quo_reg, quo_next;
    logic                                zero_reg, zero_next;
    logic                                sat_reg, sat_next;

    logic        [mmst_pkg::GAIN_W-1:0]  gain_sat;
    logic signed [mmst_pkg::P_W-1:0]     gain_ext;
    logic signed [mmst_pkg::P_W-1:0]     delta_ext;
    logic signed [mmst_pkg::M_W-1:0]     prod_ext;
    logic signed [mmst_pkg::M_W-1:0]     half_term;
    logic signed [mmst_pkg::M_W-1:0]     top_term;

    assign gain_sat  = (gain > mmst_pkg::GAIN_ONE) ? mmst_pkg::GAIN_ONE : gain;
    assign gain_ext  = $signed(mmst_pkg::P_W'(gain_sat));
    assign delta_ext = mmst_pkg::P_W'($signed(delta_reg));
    assign prod_ext  = mmst_pkg::M_W'(prod_reg);
    // range * 32768, the half-step that rounds to nearest
    assign half_term = $signed(mmst_pkg::M_W'({range_reg, {mmst_pkg::HALF_SH{1'b0}}}));
    // range * 65536 * 256: at or above this the byte clamps
    assign top_term  = $signed(mmst_pkg::M_W'(
                           {range_reg, {(mmst_pkg::DEN_SH + mmst_pkg::BYTE_W){1'b0}}}));

    always_comb
    begin
        delta_next = delta_reg;
        range_next = range_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        zero_next  = zero_reg;
        sat_next   = sat_reg;
        if (ctrl.load)
        begin
            delta_next = opnd.delta;
            range_next = opnd.range;
        end
        if (ctrl.mul)
            prod_next = gain_ext * delta_ext;
        if (ctrl.sum)
            num_next = (prod_ext <<< mmst_pkg::BYTE_W) - prod_ext + half_term;
        if (ctrl.check)
        begin
            zero_next = (range_reg == '0) || (num_reg < 0);
            sat_next  = num_reg >= top_term;
            rem_next  = num_reg[mmst_pkg::RQ_W-1:0];
            div_next  = {1'b0, range_reg, {(mmst_pkg::DEN_SH + mmst_pkg::BYTE_W - 1){1'b0}}};
            quo_next  = '0;
        end
        if (ctrl.step)
        begin
            // Restoring division, one quotient bit per cycle
            if (rem_reg >= div_reg)
            begin
                rem_next = rem_reg - div_reg;
                quo_next = {quo_reg[mmst_pkg::BYTE_W-2:0], 1'b1};
            end
            else
                quo_next = {quo_reg[mmst_pkg::BYTE_W-2:0], 1'b0};
            div_next = div_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        range_reg <= range_next;
        prod_reg  <= prod_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        quo_reg   <= quo_next;
        zero_reg  <= zero_next;
        sat_reg   <= sat_next;
    end

    assign result = zero_reg ? '0 : (sat_reg ? mmst_pkg::BYTE_MAX : quo_reg);

endmodule

`default_nettype wire

FILE: hw/rtl/mmst_back.sv
`default_nettype none

module mmst_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  mmst_pkg::q_stat_t                  q_stat,
    input  mmst_pkg::q_entry_t                 q_data,
    output logic                               pop,
    input  wire logic [mmst_pkg::GAIN_W-1:0]   red_gain,
    input  wire logic [mmst_pkg::GAIN_W-1:0]   green_gain,
    input  wire logic [mmst_pkg::GAIN_W-1:0]   blue_gain,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [mmst_pkg::BYTE_W-1:0]        red_byte,
    output logic [mmst_pkg::BYTE_W-1:0]        green_byte,
    output logic [mmst_pkg::BYTE_W-1:0]        blue_byte,
    output logic                               last_out
);

    mmst_pkg::back_state_t               state_reg, state_next;
    logic [mmst_pkg::STEP_W-1:0]         step_reg, step_next;
    logic                                last_reg, last_next;
    logic                                out_valid_reg, out_valid_next;
    logic [mmst_pkg::BYTE_W-1:0]         out_byte_reg  [mmst_pkg::NUM_CH];
    logic [mmst_pkg::BYTE_W-1:0]         out_byte_next [mmst_pkg::NUM_CH];
    logic                                out_last_reg, out_last_next;
    logic [mmst_pkg::BYTE_W-1:0]         lane_byte [mmst_pkg::NUM_CH];
    logic [mmst_pkg::GAIN_W-1:0]         lane_gain [mmst_pkg::NUM_CH];
    mmst_pkg::lane_ctrl_t                ctrl;
    logic                                emit;

    assign lane_gain[0] = red_gain;
    assign lane_gain[1] = green_gain;
    assign lane_gain[2] = blue_gain;

    for (genvar c = 0; c < mmst_pkg::NUM_CH; c++)
    begin : g_lane
        mmst_lane u_lane (
            .clk    (clk),
            .ctrl   (ctrl),
            .opnd   (q_data.ch[c]),
            .gain   (lane_gain[c]),
            .result (lane_byte[c])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmst_pkg::ST_IDLE:
                if (!q_stat.empty)
                    state_next = mmst_pkg::ST_MUL;
            mmst_pkg::ST_MUL:
                state_next = mmst_pkg::ST_SUM;
            mmst_pkg::ST_SUM:
                state_next = mmst_pkg::ST_CHECK;
            mmst_pkg::ST_CHECK:
                state_next = mmst_pkg::ST_DIV;
            mmst_pkg::ST_DIV:
                if (step_reg == mmst_pkg::LAST_STEP)
                    state_next = mmst_pkg::ST_DONE;
            mmst_pkg::ST_DONE:
                if (!out_valid_reg || m_tready)
                    state_next = mmst_pkg::ST_IDLE;
            default:
                state_next = mmst_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        ctrl = '0;
        pop  = 1'b0;
        emit = 1'b0;
        case (state_reg)
            mmst_pkg::ST_IDLE:
            begin
                pop       = !q_stat.empty;
                ctrl.load = !q_stat.empty;
            end
            mmst_pkg::ST_MUL:
                ctrl.mul = 1'b1;
            mmst_pkg::ST_SUM:
                ctrl.sum = 1'b1;
            mmst_pkg::ST_CHECK:
                ctrl.check = 1'b1;
            mmst_pkg::ST_DIV:
                ctrl.step = 1'b1;
            mmst_pkg::ST_DONE:
                emit = !out_valid_reg || m_tready;
            default:
            begin
                ctrl = '0;
                pop  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        for (int c = 0; c < mmst_pkg::NUM_CH; c++)
            out_byte_next[c] = out_byte_reg[c];
        if (ctrl.load)
            last_next = q_data.last;
        if (ctrl.check)
            step_next = '0;
        else if (ctrl.step)
            step_next = step_reg + 1'b1;
        // Hold the result until taken; a new one may replace it in the same transfer cycle
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = last_reg;
            for (int c = 0; c < mmst_pkg::NUM_CH; c++)
                out_byte_next[c] = lane_byte[c];
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmst_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        out_last_reg <= out_last_next;
        for (int c = 0; c < mmst_pkg::NUM_CH; c++)
            out_byte_reg[c] <= out_byte_next[c];
    end

    assign m_tvalid   = out_valid_reg;
    assign red_byte   = out_byte_reg[0];
    assign green_byte = out_byte_reg[1];
    assign blue_byte  = out_byte_reg[2];
    assign last_out   = out_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/three_channel_minmax_stretch.sv
`default_nettype none
`include "assert_macros.svh"

// Min/max contrast stretch for RGB pixels of three signed 32-bit samples. A measure
// transfer (tuser op = 0) updates the per-channel minimum and maximum registers,
// restarting from the pixel when the first flag is set; measure pixels give no output.
// A convert transfer (op = 1) is snapshotted with its channel deltas and ranges into a
// two-entry queue, then the back end maps each channel to a byte as
// floor((gain*255*(x-min) + range*32768) / (range*65536)), clamped to 0..255 and 0 for
// a zero range. Gains are Q1.16, reset to 1.0, and values above 1.0 act as 1.0. One
// converted pixel holds the back end for a queue pop, a 18x33 multiply, a
// scale-and-round add, a range check and a restoring division, one quotient bit per
// cycle, then the output register load. Measure pixels are taken every cycle while the
// queue has room. Gains must be written only while the block is idle (not enforced).
module three_channel_minmax_stretch (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [3*mmst_pkg::SAMPLE_WIDTH-1:0] s_tdata,  // red_sample, green_sample, blue_sample
    input  wire logic [1:0]                        s_tuser,  // op, first
    input  wire logic                              s_tlast,  // last
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [3*mmst_pkg::BYTE_W-1:0]          m_tdata,  // red_byte, green_byte, blue_byte
    output logic                                   m_tlast,  // last_out
    input  wire logic                              wr_en,
    input  wire logic [mmst_pkg::IDX_W-1:0]        wr_index,
    input  wire logic [mmst_pkg::GAIN_W-1:0]       wr_data
);

    localparam int SW = mmst_pkg::SAMPLE_WIDTH;
    localparam int BW = mmst_pkg::BYTE_W;

    logic [mmst_pkg::GAIN_W-1:0] red_gain_reg, red_gain_next;
    logic [mmst_pkg::GAIN_W-1:0] green_gain_reg, green_gain_next;
    logic [mmst_pkg::GAIN_W-1:0] blue_gain_reg, blue_gain_next;

    logic                 q_push;
    logic                 q_pop;
    mmst_pkg::q_entry_t   q_push_data;
    mmst_pkg::q_entry_t   q_pop_data;
    mmst_pkg::q_stat_t    q_stat;
    logic [BW-1:0]        red_byte;
    logic [BW-1:0]        green_byte;
    logic [BW-1:0]        blue_byte;

    always_comb
    begin
        red_gain_next   = red_gain_reg;
        green_gain_next = green_gain_reg;
        blue_gain_next  = blue_gain_reg;
        if (wr_en)
        begin
            case (wr_index)
                mmst_pkg::CFG_RED_GAIN:   red_gain_next   = wr_data;
                mmst_pkg::CFG_GREEN_GAIN: green_gain_next = wr_data;
                mmst_pkg::CFG_BLUE_GAIN:  blue_gain_next  = wr_data;
                default:
                begin
                    red_gain_next   = red_gain_reg;
                    green_gain_next = green_gain_reg;
                    blue_gain_next  = blue_gain_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_gain_reg   <= mmst_pkg::GAIN_ONE;
            green_gain_reg <= mmst_pkg::GAIN_ONE;
            blue_gain_reg  <= mmst_pkg::GAIN_ONE;
        end
        else
        begin
            red_gain_reg   <= red_gain_next;
            green_gain_reg <= green_gain_next;
            blue_gain_reg  <= blue_gain_next;
        end
    end

    mmst_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .op           (s_tuser[0]),
        .first        (s_tuser[1]),
        .red_sample   (s_tdata[SW-1:0]),
        .green_sample (s_tdata[2*SW-1:SW]),
        .blue_sample  (s_tdata[3*SW-1:2*SW]),
        .last         (s_tlast),
        .q_full       (q_stat.full),
        .push         (q_push),
        .push_data    (q_push_data)
    );

    mmst_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .stat      (q_stat)
    );

    mmst_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .q_data     (q_pop_data),
        .pop        (q_pop),
        .red_gain   (red_gain_reg),
        .green_gain (green_gain_reg),
        .blue_gain  (blue_gain_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .red_byte   (red_byte),
        .green_byte (green_byte),
        .blue_byte  (blue_byte),
        .last_out   (m_tlast)
    );

    assign m_tdata = {blue_byte, green_byte, red_byte};

    `CHK_IMPLY(a_q_bound, clk, rst_n, 1'b1, q_stat.count <= mmst_pkg::Q_CNT_W'(mmst_pkg::Q_DEPTH))
    `CHK_IMPLY(a_pop_nonempty, clk, rst_n, q_pop, !q_stat.empty)
    `CHK_IMPLY(a_measure_no_push, clk, rst_n, s_tvalid && s_tready && !s_tuser[0], !q_push)
    `CHK_NEXT(a_push_fills, clk, rst_n, q_push && !q_pop, q_stat.count != '0)

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int SW          = mmst_pkg::SAMPLE_WIDTH;
    localparam int BYTE_W      = mmst_pkg::BYTE_W;
    localparam int GAIN_W      = mmst_pkg::GAIN_W;
    localparam int IDX_W       = mmst_pkg::IDX_W;
    localparam int NUM_CH      = mmst_pkg::NUM_CH;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 40;
    localparam int PHASE_ITEMS = 275;

    localparam logic [GAIN_W-1:0] GAIN_ONE = mmst_pkg::GAIN_ONE;

    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

    localparam logic [IDX_W-1:0] GAIN_REG [NUM_CH] = '{mmst_pkg::CFG_RED_GAIN,
                                                      mmst_pkg::CFG_GREEN_GAIN,
                                                      mmst_pkg::CFG_BLUE_GAIN};

    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
    } pixel_bytes_t;

    class stretch_scoreboard;
        logic [GAIN_W-1:0] gain [NUM_CH];
        longint            ch_min [NUM_CH];
        longint            ch_max [NUM_CH];
        pixel_bytes_t      pending_pixels [$];
        int unsigned       fail_count;

        function new();
            for (int c = 0; c < NUM_CH; c++)
            begin
                gain[c]   = GAIN_ONE;
                ch_min[c] = 0;
                ch_max[c] = 0;
            end
            fail_count = 0;
        endfunction

        function void set_gain(int c, logic [GAIN_W-1:0] value);
            gain[c] = value;
        endfunction

        function logic [BYTE_W-1:0] stretch_channel(longint x, longint mn, longint mx,
                                                     logic [GAIN_W-1:0] g_raw);
            longint rng;
            longint d;
            longint g;
            longint num;
            longint den;
            longint q;
            rng = mx - mn;
            d   = x - mn;
            // hold gains above unity at unity
            g   = (g_raw > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(g_raw);
            if (rng <= 0)
                return '0;
            num = 2 * g * 255 * d + rng * 65536;
            den = rng * 131072;
            if (num < 0)
                return '0;
            q = num / den;
            if (q > 255)
                q = 255;
            return q[BYTE_W-1:0];
        endfunction

        function void note_input(bit op, bit first, logic [3*SW-1:0] samples, bit last);
            longint       x [NUM_CH];
            pixel_bytes_t px;
            for (int c = 0; c < NUM_CH; c++)
                x[c] = longint'($signed(samples[SW*c +: SW]));
            if (!op)
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    if (first)
                    begin
                        ch_min[c] = x[c];
                        ch_max[c] = x[c];
                    end
                    else
                    begin
                        if (x[c] < ch_min[c])
                            ch_min[c] = x[c];
                        if (x[c] > ch_max[c])
                            ch_max[c] = x[c];
                    end
                end
                return;
            end
            px.red   = stretch_channel(x[0], ch_min[0], ch_max[0], gain[0]);
            px.green = stretch_channel(x[1], ch_min[1], ch_max[1], gain[1]);
            px.blue  = stretch_channel(x[2], ch_min[2], ch_max[2], gain[2]);
            px.last  = last;
            pending_pixels.push_back(px);
        endfunction

        function void check_result(logic [3*BYTE_W-1:0] data, logic last);
            pixel_bytes_t got;
            pixel_bytes_t want;
            got = {last, data};
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected output transfer: data %h last %b", data, last);
                fail_count++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.red !== want.red)
            begin
                $error("red_byte: expected %0d, got %0d", want.red, got.red);
                fail_count++;
            end
            if (got.green !== want.green)
            begin
                $error("green_byte: expected %0d, got %0d", want.green, got.green);
                fail_count++;
            end
            if (got.blue !== want.blue)
            begin
                $error("blue_byte: expected %0d, got %0d", want.blue, got.blue);
                fail_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last_out: expected %0b, got %0b", want.last, got.last);
                fail_count++;
            end
        endfunction

        function int outstanding();
            return pending_pixels.size();
        endfunction
    endclass

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [3*SW-1:0]         s_tdata  = '0;   // red_sample, green_sample, blue_sample
    logic [1:0]              s_tuser  = '0;   // op, first
    logic                    s_tlast  = 1'b0; // last
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [3*BYTE_W-1:0]     m_tdata;         // red_byte, green_byte, blue_byte
    logic                    m_tlast;         // last_out
    logic                    wr_en    = 1'b0;
    logic [IDX_W-1:0]        wr_index = '0;
    logic [GAIN_W-1:0]       wr_data  = '0;

    int                src_idle_pct = 31;
    int                snk_idle_pct = 55;
    int                stall_cycles = 0;
    int                items_sent   = 0;
    stretch_scoreboard sb = new();

    three_channel_minmax_stretch u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    // check output transfers, throttle the sink and count cycles with no transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_pixel(input bit op, input bit first, input logic [SW-1:0] red,
                              input logic [SW-1:0] green, input logic [SW-1:0] blue,
                              input bit last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {first, op};
        s_tdata  <= {blue, green, red};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(op, first, {blue, green, red}, last);
        items_sent++;
    endtask

    // drop valid, wait for every pending pixel, then let the back end go quiet
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_gains(input logic [GAIN_W-1:0] red, input logic [GAIN_W-1:0] green,
                               input logic [GAIN_W-1:0] blue);
        logic [GAIN_W-1:0] vals [NUM_CH];
        vals = '{red, green, blue};
        for (int c = 0; c < NUM_CH; c++)
        begin
            wr_en    <= 1'b1;
            wr_index <= GAIN_REG[c];
            wr_data  <= vals[c];
            @(posedge clk);
            sb.set_gain(c, vals[c]);
        end
        wr_en <= 1'b0;
    endtask

    function automatic logic [SW-1:0] clamp_sample(longint v);
        if (v < longint'($signed(S_MIN)))
            return S_MIN;
        if (v > longint'($signed(S_MAX)))
            return S_MAX;
        return v[SW-1:0];
    endfunction

    // one measure pass followed by one convert pass
    task automatic run_frame();
        int            n_meas;
        int            n_conv;
        int            bits [NUM_CH];
        longint        base [NUM_CH];
        logic [SW-1:0] s [NUM_CH];
        longint        lo;
        longint        hi;
        int            pick;
        bit            first;
        n_meas = $urandom_range(1, 10);
        n_conv = $urandom_range(1, 12);
        for (int c = 0; c < NUM_CH; c++)
        begin
            bits[c] = ($urandom_range(3) == 0) ? 32 : $urandom_range(0, 24);
            base[c] = longint'($signed($urandom));
        end
        for (int i = 0; i < n_meas; i++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (bits[c] == 32)
                    s[c] = $urandom;
                else
                    s[c] = clamp_sample(base[c] +
                                        longint'($urandom & ((32'd1 << bits[c]) - 1)));
            end
            // now and then carry the old range over into this pass
            first = (i == 0) && ($urandom_range(7) != 0);
            send_pixel(1'b0, first, s[0], s[1], s[2], 1'b0);
        end
        for (int j = 0; j < n_conv; j++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                lo   = sb.ch_min[c];
                hi   = sb.ch_max[c];
                pick = $urandom_range(9);
                if (pick < 8)
                    s[c] = clamp_sample(lo + longint'($urandom) % (hi - lo + 1));
                else if (pick == 8)
                    s[c] = $urandom;
                else if ($urandom_range(1))
                    s[c] = clamp_sample(lo - longint'($urandom_range(1, 1000)));
                else
                    s[c] = clamp_sample(hi + longint'($urandom_range(1, 1000)));
            end
            send_pixel(1'b1, ($urandom_range(9) == 0), s[0], s[1], s[2], (j == n_conv - 1));
        end
    endtask

    initial
    begin
        int phase_start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // convert before any measure: zero range everywhere
        send_pixel(1'b1, 1'b0, 32'd5, S_MIN, S_MAX, 1'b0);
        // full-scale red, flat green and blue; last on a measure pixel
        send_pixel(1'b0, 1'b1, S_MIN, 32'd0, 32'd5, 1'b0);
        send_pixel(1'b0, 1'b0, S_MAX, 32'd0, 32'd5, 1'b1);
        send_pixel(1'b1, 1'b0, S_MIN, 32'd0, 32'd5, 1'b0);
        send_pixel(1'b1, 1'b0, S_MAX, 32'd0, 32'd5, 1'b0);
        send_pixel(1'b1, 1'b0, 32'd0, 32'd1, 32'd4, 1'b1);
        // narrow ranges, samples below and above them (blue at its minimum and above)
        send_pixel(1'b0, 1'b1, 32'd100, -32'sd50, S_MIN, 1'b0);
        send_pixel(1'b0, 1'b0, 32'd355, 32'd50, S_MIN + 32'd1000, 1'b0);
        send_pixel(1'b1, 1'b0, 32'd99, -32'sd51, S_MIN, 1'b0);
        send_pixel(1'b1, 1'b0, 32'd400, 32'd60, S_MIN + 32'd2000, 1'b0);
        // first on a convert pixel must not restart the range
        send_pixel(1'b1, 1'b1, 32'd227, 32'd0, S_MIN + 32'd500, 1'b0);
        send_pixel(1'b0, 1'b0, 32'd1000, -32'sd1000, S_MAX, 1'b0);
        send_pixel(1'b1, 1'b0, 32'd1000, -32'sd1000, S_MAX, 1'b0);
        send_pixel(1'b1, 1'b0, 32'd550, 32'd0, 32'd0, 1'b1);
        send_pixel(1'b0, 1'b1, S_MAX, S_MAX, S_MAX, 1'b0);
        send_pixel(1'b1, 1'b0, S_MAX, S_MAX, S_MAX, 1'b0);
        send_pixel(1'b1, 1'b0, S_MIN, S_MIN, S_MIN, 1'b1);
        drain_and_settle();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    src_idle_pct <= 31;
                    snk_idle_pct <= 55;
                end
                1:
                begin
                    src_idle_pct <= 55;
                    snk_idle_pct <= 31;
                end
                default:
                begin
                    src_idle_pct <= 0;
                    snk_idle_pct <= 0;
                end
            endcase
            case (phase)
                0:       write_gains(17'd0, 17'h1FFFF, 17'd32768);
                1:       write_gains(GAIN_ONE, 17'd1, 17'd65535);
                2:       write_gains(17'h1FFFF, 17'd0, GAIN_ONE);
                3:       write_gains(17'd49152, 17'd16384, 17'h10001);
                4:       write_gains(GAIN_W'($urandom_range(0, 17'h1FFFF)),
                                     GAIN_W'($urandom_range(0, 17'h1FFFF)),
                                     GAIN_W'($urandom_range(0, 17'h1FFFF)));
                default: write_gains(GAIN_ONE, GAIN_ONE, GAIN_ONE);
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 15)
                    send_pixel(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                               $urandom, $urandom, 1'($urandom_range(1)));
                else
                    run_frame();
            end
            drain_and_settle();
        end

        if (sb.fail_count == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: three_channel_minmax_stretch.f
+incdir+hw/rtl
hw/rtl/mmst_pkg.sv
hw/rtl/mmst_front.sv
hw/rtl/mmst_fifo.sv
hw/rtl/mmst_lane.sv
hw/rtl/mmst_back.sv
hw/rtl/three_channel_minmax_stretch.sv
sim/tb.sv
